[rtl/b64e_pkg.sv]
// b64e_pkg: shared types, constants and the sextet-to-ASCII mapping
// for the base64 stream encoder. No dependencies.
package b64e_pkg;

  // Position of the next byte inside a three-byte group
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One encoded byte: up to four characters, emitted from index 0 up
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;  // number of characters minus one
    logic            last;    // final character closes the payload
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[rtl/b64e_front.sv]
// b64e_front: accepts bytes, tracks group position and carry bits, and
// turns each byte into a character job. Depends on b64e_pkg.
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output b64e_pkg::job_t  job
);

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Encode the byte against the current group position
  always_comb begin
    job       = '0;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    case (pos_r)
      b64e_pkg::POS_SECOND: begin
        job.chars[0] = b64e_pkg::sextet_char({carry_r[1:0], in_data_byte[7:4]});
        if (in_last_byte) begin
          job.chars[1] = b64e_pkg::sextet_char({in_data_byte[3:0], 2'b00});
          job.chars[2] = b64e_pkg::PAD_CHAR;
          job.cnt_m1   = 2'd2;
          job.last     = 1'b1;
          pos_nxt      = b64e_pkg::POS_FIRST;
          carry_nxt    = 4'd0;
        end else begin
          job.cnt_m1   = 2'd0;
          pos_nxt      = b64e_pkg::POS_THIRD;
          carry_nxt    = in_data_byte[3:0];
        end
      end
      b64e_pkg::POS_THIRD: begin
        job.chars[0] = b64e_pkg::sextet_char({carry_r, in_data_byte[7:6]});
        job.chars[1] = b64e_pkg::sextet_char(in_data_byte[5:0]);
        job.cnt_m1   = 2'd1;
        job.last     = in_last_byte;
        pos_nxt      = b64e_pkg::POS_FIRST;
        carry_nxt    = 4'd0;
      end
      // first byte of a group (unreachable code three lands here too)
      default: begin
        job.chars[0] = b64e_pkg::sextet_char(in_data_byte[7:2]);
        if (in_last_byte) begin
          job.chars[1] = b64e_pkg::sextet_char({in_data_byte[1:0], 4'b0000});
          job.chars[2] = b64e_pkg::PAD_CHAR;
          job.chars[3] = b64e_pkg::PAD_CHAR;
          job.cnt_m1   = 2'd3;
          job.last     = 1'b1;
          pos_nxt      = b64e_pkg::POS_FIRST;
          carry_nxt    = 4'd0;
        end else begin
          job.cnt_m1   = 2'd0;
          pos_nxt      = b64e_pkg::POS_SECOND;
          carry_nxt    = {2'b00, in_data_byte[1:0]};
        end
      end
    endcase
  end

  // Group state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= b64e_pkg::POS_FIRST;
      carry_r <= 4'd0;
    end else if (push) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

[rtl/b64e_fifo.sv]
// b64e_fifo: short job queue between the front and back parts.
// Depends on b64e_pkg.
module b64e_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64e_pkg::job_t  push_job,
  input  logic            pop,
  output b64e_pkg::job_t  head_job,
  output logic            full,
  output logic            empty
);

  b64e_pkg::job_t                 q_r [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/b64e_back.sv]
// b64e_back: takes jobs from the queue and emits one character per beat
// from a held job register. Depends on b64e_pkg.
module b64e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  b64e_pkg::job_t  head_job,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last_char
);

  b64e_pkg::job_t job_r;
  logic           busy_r;
  logic [1:0]     idx_r;
  logic           at_end;
  logic           take;

  assign at_end = (idx_r == job_r.cnt_m1);
  assign take   = out_valid && out_ready;
  assign pop    = !q_empty && (!busy_r || (take && at_end));

  assign out_valid     = busy_r;
  assign out_char      = job_r.chars[idx_r];
  assign out_last_char = job_r.last && at_end;

  // Job register: loaded on pop, payload without reset
  always_ff @(posedge clk) begin
    if (pop) job_r <= head_job;
  end

  // Character index and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (take) begin
      if (at_end) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else begin
        idx_r  <= idx_r + 1'b1;
      end
    end
  end

endmodule

[rtl/base64_stream_encoder.sv]
// base64_stream_encoder: top level, front encoder, job queue and
// character serializer. Depends on b64e_pkg, b64e_front, b64e_fifo, b64e_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per beat
//   with in_last_byte on the final byte. Output channel (out_valid/
//   out_ready) carries one base64 character per beat, out_last_char on
//   the final character of a payload; partial groups are padded with '='.
//   The first character of a byte is written into the queue at the edge
//   that accepts the byte, then loaded into the serializer's job
//   register, which waits while the serializer is busy; it is valid
//   from that load on. The serializer emits one character per cycle
//   while jobs are queued and out_ready is high, so a byte yields 1, 2,
//   3 or 4 characters; a long payload sustains four characters per
//   three bytes. The rate is set by the single output port of the
//   serializer. A four-entry job queue decouples the two sides: the front
//   keeps taking bytes while the receiver stalls, until the queue is full,
//   at which point in_ready drops.
//   Reset (rst_n low, synchronous) empties the queue and returns the group
//   position to the start of a payload.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  b64e_pkg::job_t push_job;
  b64e_pkg::job_t head_job;
  logic           push, pop, q_full, q_empty;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .in_ready     (in_ready),
    .push         (push),
    .job          (push_job)
  );

  b64e_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule
